FILE: design/rpcc_pkg.sv
package rpcc_pkg;

  // Default term counts of the erf series and continued fraction
  localparam int SERIES_TERMS_DEF   = 32;
  localparam int FRACTION_TERMS_DEF = 32;
  localparam int EXP_TERMS          = 16;
  localparam int EXP_SQUARINGS      = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Q31.32 constants
  localparam logic [63:0] Q_ONE       = 64'h0000_0001_0000_0000;
  localparam logic [63:0] C_TWO_RTPI  = 64'd4846351620;   // 2/sqrt(pi)
  localparam logic [63:0] C_ONE_RTPI  = 64'd2423175810;   // 1/sqrt(pi)
  localparam logic [63:0] C_INV_RT2   = 64'd3037000499;   // 1/sqrt(2)
  localparam logic [63:0] C_Z_SERIES  = 64'd9448928051;   // 2.2
  localparam logic [63:0] C_Z_SAT     = 64'd25769803776;  // 6.0
  localparam logic [63:0] RATIO_CAP   = 64'd68719476736;  // 16.0
  localparam logic [63:0] CHANGE_CAP  = 64'd1099511627776; // 2^40
  localparam logic [63:0] INT64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    MODE_NONE, MODE_RAMP, MODE_CND, MODE_DUTY, MODE_THIRD, MODE_CUTOFF
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE, REG_SENS, REG_RAMP_HIGH, REG_RAMP_LOW, REG_RANGE_HIGH,
    REG_RANGE_LOW, REG_BASE
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_R_MUL1, S_R_MUL2, S_R_MUL3, S_R_DIV, S_R_FIN,
    S_C_RATIO, S_C_Z, S_C_ZZ, S_C_SMUL, S_C_SDIVK, S_C_SDIVP, S_C_SFIN,
    S_C_CFDIV, S_C_INV, S_C_U, S_C_EMUL, S_C_EDIV, S_C_ESQ, S_C_T1, S_C_T2,
    S_C_PROB, S_DONE
  } ctl_state_t;

  typedef struct packed {
    logic signed [31:0] measured;
    logic signed [31:0] expected;
    logic signed [31:0] mean_value;
    logic [30:0]        std_dev;
    logic [15:0]        random_fraction;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_setpoint;
    logic               turn_off;
    logic [30:0]        off_probability;
    logic               mode_error;
  } out_t;

  // Request to the shared multiply / divide unit
  typedef struct packed {
    logic        go_mul;
    logic        go_div;
    logic        div_short;
    logic [63:0] num_hi;
    logic [63:0] opa;
    logic [63:0] opb;
  } arith_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
    logic [63:0]  quo;
  } arith_rsp_t;

endpackage

FILE: design/ramp_and_probabilistic_cutoff_control_top.sv
// Ramp and probabilistic-cutoff setpoint controller.
// Configuration: cfg_we writes cfg_wdata into the register cfg_idx
// (mode, sensitivity, ramp slopes, change limits, base setpoint); write
// only while the block is idle. Indexes beyond the list are ignored.
// Input: one item per controller cycle on in_valid / in_stall; in_stall is
// high while an item is being worked on. Output: one result item per input
// on out_valid / out_stall, held in an output register so the next item
// can be taken while a result still waits.
// One shared unit does the arithmetic: a 4-pass 32x32 multiplier and a
// 1-bit-per-cycle divider. Hold modes need no arithmetic. Ramp uses at most
// three products and a division. Cutoff sums the series over SERIES_TERMS
// terms, or the continued fraction over FRACTION_TERMS terms and then an exp series and squarings.
// One item is in work at a time.
// Reset (synchronous, rst_n low) clears the registers to their defaults,
// the held outputs to zero and empties the output register. While the
// receiver stalls, the finished result waits in its final step and no new
// item is taken after the one already accepted.
module ramp_and_probabilistic_cutoff_control_top import rpcc_pkg::*; #(
  parameter int SERIES_TERMS   = SERIES_TERMS_DEF,
  parameter int FRACTION_TERMS = FRACTION_TERMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data
);

  localparam int MAX_A = (SERIES_TERMS > FRACTION_TERMS) ? SERIES_TERMS : FRACTION_TERMS;
  localparam int MAX_T = (MAX_A > EXP_TERMS) ? MAX_A : EXP_TERMS;
  localparam int KW    = $clog2(2 * MAX_T + 2);

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Q31.32 product with saturation and sign
  function automatic logic [63:0] fix_res(input logic [127:0] p, input logic neg);
    logic [63:0] r;
    r = p[95:32];
    if ((p[127:96] != '0) || r[63]) begin
      r = INT64_MAX;
    end
    return neg ? -r : r;
  endfunction

  function automatic logic [63:0] div_fix(input logic [63:0] q, input logic neg);
    logic [63:0] r;
    r = q[63] ? INT64_MAX : q;
    return neg ? -r : r;
  endfunction

  function automatic logic [63:0] clamp_e(input logic [63:0] v);
    logic [63:0] r;
    r = v;
    if (v[63]) begin
      r = '0;
    end else if (v > Q_ONE) begin
      r = Q_ONE;
    end
    return r;
  endfunction

  logic [2:0]         mode_r;
  logic signed [31:0] sens_r, rh_r, rl_r, rgh_r, rgl_r, base_r;
  logic signed [31:0] held_sp_r;
  logic               held_off_r;
  logic [31:0]        held_prob_r;
  in_t                item_r;
  logic               err_r;
  ctl_state_t         state_r, state_nxt;
  logic               issued_r, issued_nxt;
  arith_req_t         req;
  arith_rsp_t         rsp;
  logic               req_neg, op_neg_r, op_done;
  logic [63:0]        wide_hi_r, wide_lo_r, den_r;
  logic [63:0]        z_r, zz_r, acc_r, pw_r, t_r, ex_r, inv_r, e_r;
  logic [KW-1:0]      k_r;
  logic signed [41:0] change_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic signed [32:0] rdev, cdev;
  logic               r_above, r_neg;
  logic signed [31:0] r_slope, r_limit;
  logic [63:0]        rdev_mag, cdev_mag, lim_mag, sens_mag, slope_mag, sd64;
  logic [63:0]        mul_fix, div_s, div_fx, e_sgn, k_ext, k_odd, cf_mu;
  logic [40:0]        q_cap;
  logic signed [41:0] chg_div, chg_cap, rgh42, rgl42, c1, c2;
  logic signed [42:0] total;
  logic signed [31:0] total_sat;
  logic [63:0]        prob;
  logic               err_mode;

  rpcc_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Ramp operand selection
  assign rdev      = {item_r.measured[31], item_r.measured}
                   - {item_r.expected[31], item_r.expected};
  assign r_above   = rdev > 33'sd0;
  assign r_slope   = r_above ? rh_r : rl_r;
  assign r_limit   = r_above ? ((r_slope > 32'sd0) ? rgh_r : rgl_r)
                             : ((r_slope > 32'sd0) ? rgl_r : rgh_r);
  assign r_neg     = rdev[32] ^ sens_r[31];
  assign rdev_mag  = mag64({{31{rdev[32]}}, rdev});
  assign lim_mag   = mag64({{32{r_limit[31]}}, r_limit});
  assign sens_mag  = mag64({{32{sens_r[31]}}, sens_r});
  assign slope_mag = mag64({{32{r_slope[31]}}, r_slope});
  assign sd64      = {33'b0, item_r.std_dev};

  // Cutoff deviation and loop indexes
  assign cdev     = {item_r.measured[31], item_r.measured}
                  - {item_r.mean_value[31], item_r.mean_value};
  assign cdev_mag = mag64({{31{cdev[32]}}, cdev});
  assign k_ext    = {{(64-KW){1'b0}}, k_r};
  assign k_odd    = {{(63-KW){1'b0}}, k_r, 1'b1};
  assign cf_mu    = k_ext << 31;
  assign e_sgn    = cdev[32] ? -e_r : e_r;

  // Results of the shared unit
  assign op_done = issued_r && rsp.done;
  assign mul_fix = fix_res(rsp.prod, op_neg_r);
  assign div_s   = op_neg_r ? -rsp.quo : rsp.quo;
  assign div_fx  = div_fix(rsp.quo, op_neg_r);

  // Ramp change: cap, clamp and add
  assign q_cap     = (rsp.quo > CHANGE_CAP) ? CHANGE_CAP[40:0] : rsp.quo[40:0];
  assign chg_div   = (r_neg ^ r_slope[31]) ? -{1'b0, q_cap} : {1'b0, q_cap};
  assign chg_cap   = r_neg ? -$signed({1'b0, CHANGE_CAP[40:0]})
                           : $signed({1'b0, CHANGE_CAP[40:0]});
  assign rgh42     = {{10{rgh_r[31]}}, rgh_r};
  assign rgl42     = {{10{rgl_r[31]}}, rgl_r};
  assign c1        = (change_r > rgh42) ? rgh42 : change_r;
  assign c2        = (c1 < rgl42) ? rgl42 : c1;
  assign total     = {{11{base_r[31]}}, base_r} + {c2[41], c2};
  assign total_sat = (total > 43'sd2147483647) ? 32'sh7FFF_FFFF :
                     (total < -43'sd2147483648) ? 32'sh8000_0000 : total[31:0];

  // Probability halved toward zero
  assign prob = $signed(mul_fix + {63'b0, mul_fix[63]}) >>> 1;

  assign err_mode = (mode_t'(mode_r) == MODE_DUTY) || (mode_r > MODE_CUTOFF);

  // Next state
  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    if (op_done) begin
      issued_nxt = 1'b0;
    end else if (req.go_mul || req.go_div) begin
      issued_nxt = 1'b1;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (mode_t'(mode_r))
          MODE_RAMP: begin
            state_nxt = ((sens_r == '0) || (item_r.std_dev == '0)) ? S_R_FIN : S_R_MUL1;
          end
          MODE_CUTOFF: begin
            state_nxt = (item_r.std_dev == '0) ? S_DONE : S_C_RATIO;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_R_MUL1:  if (op_done) state_nxt = S_R_MUL2;
      S_R_MUL2: begin
        if (op_done) begin
          state_nxt = ((rsp.prod == '0) || (r_slope == '0)) ? S_R_FIN : S_R_MUL3;
        end
      end
      S_R_MUL3:  if (op_done) state_nxt = S_R_DIV;
      S_R_DIV:   if (op_done) state_nxt = S_R_FIN;
      S_R_FIN:   state_nxt = S_DONE;
      S_C_RATIO: if (op_done) state_nxt = S_C_Z;
      S_C_Z: begin
        if (op_done) begin
          if (mul_fix <= C_Z_SERIES) begin
            state_nxt = S_C_ZZ;
          end else if (mul_fix >= C_Z_SAT) begin
            state_nxt = S_C_PROB;
          end else begin
            state_nxt = S_C_CFDIV;
          end
        end
      end
      S_C_ZZ:    if (op_done) state_nxt = S_C_SMUL;
      S_C_SMUL:  if (op_done) state_nxt = S_C_SDIVK;
      S_C_SDIVK: if (op_done) state_nxt = S_C_SDIVP;
      S_C_SDIVP: begin
        if (op_done) begin
          state_nxt = (k_r == KW'(SERIES_TERMS)) ? S_C_SFIN : S_C_SMUL;
        end
      end
      S_C_SFIN:  if (op_done) state_nxt = S_C_PROB;
      S_C_CFDIV: if (op_done && (k_r == KW'(1))) state_nxt = S_C_INV;
      S_C_INV:   if (op_done) state_nxt = S_C_U;
      S_C_U:     if (op_done) state_nxt = S_C_EMUL;
      S_C_EMUL:  if (op_done) state_nxt = S_C_EDIV;
      S_C_EDIV: begin
        if (op_done) begin
          state_nxt = (k_r == KW'(EXP_TERMS)) ? S_C_ESQ : S_C_EMUL;
        end
      end
      S_C_ESQ:   if (op_done && (k_r == KW'(EXP_SQUARINGS - 1))) state_nxt = S_C_T1;
      S_C_T1:    if (op_done) state_nxt = S_C_T2;
      S_C_T2:    if (op_done) state_nxt = S_C_PROB;
      S_C_PROB:  if (op_done) state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Shared unit requests
  always_comb begin
    req     = '0;
    req_neg = 1'b0;
    case (state_r)
      S_R_MUL1: begin
        req.go_mul = !issued_r;
        req.opa    = rdev_mag;
        req.opb    = lim_mag;
      end
      S_R_MUL2: begin
        req.go_mul = !issued_r;
        req.opa    = wide_lo_r;
        req.opb    = sens_mag;
      end
      S_R_MUL3: begin
        req.go_mul = !issued_r;
        req.opa    = slope_mag;
        req.opb    = sd64;
      end
      S_R_DIV: begin
        req.go_div = !issued_r;
        req.num_hi = wide_hi_r;
        req.opa    = wide_lo_r;
        req.opb    = den_r;
      end
      S_C_RATIO: begin
        req.go_div = !issued_r;
        req.num_hi = {63'b0, cdev_mag[32]};
        req.opa    = {cdev_mag[31:0], 32'b0};
        req.opb    = sd64;
      end
      S_C_Z: begin
        req.go_mul = !issued_r;
        req.opa    = t_r;
        req.opb    = C_INV_RT2;
      end
      S_C_ZZ, S_C_U: begin
        req.go_mul = !issued_r;
        req.opa    = z_r;
        req.opb    = z_r;
      end
      S_C_SMUL, S_C_EMUL: begin
        req.go_mul = !issued_r;
        req.opa    = mag64(pw_r);
        req.opb    = mag64(zz_r);
        req_neg    = pw_r[63] ^ zz_r[63];
      end
      S_C_SDIVK, S_C_EDIV: begin
        req.go_div    = !issued_r;
        req.div_short = 1'b1;
        req.opa       = mag64(t_r);
        req.opb       = k_ext;
        req_neg       = t_r[63];
      end
      S_C_SDIVP: begin
        req.go_div    = !issued_r;
        req.div_short = 1'b1;
        req.opa       = mag64(pw_r);
        req.opb       = k_odd;
        req_neg       = pw_r[63];
      end
      S_C_SFIN: begin
        req.go_mul = !issued_r;
        req.opa    = C_TWO_RTPI;
        req.opb    = mag64(acc_r);
        req_neg    = acc_r[63];
      end
      S_C_CFDIV: begin
        req.go_div = !issued_r;
        req.num_hi = {32'b0, cf_mu[63:32]};
        req.opa    = {cf_mu[31:0], 32'b0};
        req.opb    = mag64(den_r);
        req_neg    = den_r[63];
      end
      S_C_INV: begin
        req.go_div = !issued_r;
        req.num_hi = 64'd1;
        req.opa    = '0;
        req.opb    = mag64(den_r);
        req_neg    = den_r[63];
      end
      S_C_ESQ: begin
        req.go_mul = !issued_r;
        req.opa    = mag64(ex_r);
        req.opb    = mag64(ex_r);
      end
      S_C_T1: begin
        req.go_mul = !issued_r;
        req.opa    = C_ONE_RTPI;
        req.opb    = mag64(ex_r);
        req_neg    = ex_r[63];
      end
      S_C_T2: begin
        req.go_mul = !issued_r;
        req.opa    = mag64(t_r);
        req.opb    = mag64(inv_r);
        req_neg    = t_r[63] ^ inv_r[63];
      end
      S_C_PROB: begin
        req.go_mul = !issued_r;
        req.opa    = sens_mag;
        req.opb    = mag64(e_sgn);
        req_neg    = sens_r[31] ^ e_sgn[63];
      end
      default: ;
    endcase
  end

  // Control, configuration and held outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_NONE;
      sens_r      <= 32'sd65536;
      rh_r        <= '0;
      rl_r        <= '0;
      rgh_r       <= '0;
      rgl_r       <= '0;
      base_r      <= '0;
      held_sp_r   <= '0;
      held_off_r  <= 1'b0;
      held_prob_r <= '0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;

      if (cfg_we) begin
        case (cfg_idx)
          REG_MODE:       mode_r <= cfg_wdata[2:0];
          REG_SENS:       sens_r <= cfg_wdata;
          REG_RAMP_HIGH:  rh_r   <= cfg_wdata;
          REG_RAMP_LOW:   rl_r   <= cfg_wdata;
          REG_RANGE_HIGH: rgh_r  <= cfg_wdata;
          REG_RANGE_LOW:  rgl_r  <= cfg_wdata;
          REG_BASE:       base_r <= cfg_wdata;
          default: ;
        endcase
      end

      // Update held outputs
      if (state_r == S_R_FIN) begin
        held_sp_r  <= total_sat;
        held_off_r <= 1'b0;
      end
      if ((state_r == S_DISP) && (mode_t'(mode_r) == MODE_CUTOFF)
          && (item_r.std_dev == '0)) begin
        held_off_r  <= cdev > 33'sd0;
        held_prob_r <= (cdev > 33'sd0) ? 32'd65536 : 32'd0;
      end
      if ((state_r == S_C_PROB) && op_done) begin
        held_off_r  <= $signed({48'b0, item_r.random_fraction}) < $signed(prob);
        held_prob_r <= prob[63] ? 32'd0 : prob[31:0];
      end

      // Present the result, drop it once taken
      if ((state_r == S_DONE) && (!out_valid_r || !out_stall)) begin
        out_valid_r                <= 1'b1;
        out_data_r.new_setpoint    <= held_sp_r;
        out_data_r.turn_off        <= held_off_r;
        out_data_r.off_probability <= held_prob_r[30:0];
        out_data_r.mode_error      <= err_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      item_r <= in_data;
    end
    if (req.go_mul || req.go_div) begin
      op_neg_r <= req_neg;
    end
    case (state_r)
      S_DISP: begin
        change_r <= '0;
        err_r    <= err_mode;
      end
      S_R_MUL1: if (op_done) wide_lo_r <= rsp.prod[63:0];
      S_R_MUL2: begin
        if (op_done) begin
          wide_hi_r <= rsp.prod[127:64];
          wide_lo_r <= rsp.prod[63:0];
          if ((rsp.prod != '0) && (r_slope == '0)) begin
            change_r <= chg_cap;
          end
        end
      end
      S_R_MUL3:  if (op_done) den_r <= rsp.prod[63:0];
      S_R_DIV:   if (op_done) change_r <= chg_div;
      S_C_RATIO: if (op_done) t_r <= (rsp.quo > RATIO_CAP) ? RATIO_CAP : rsp.quo;
      S_C_Z: begin
        if (op_done) begin
          z_r   <= mul_fix;
          den_r <= mul_fix;
          k_r   <= KW'(FRACTION_TERMS);
          e_r   <= Q_ONE;
        end
      end
      S_C_ZZ: begin
        if (op_done) begin
          zz_r  <= mul_fix;
          acc_r <= z_r;
          pw_r  <= z_r;
          k_r   <= KW'(1);
        end
      end
      S_C_SMUL, S_C_EMUL, S_C_T1: if (op_done) t_r <= mul_fix;
      S_C_SDIVK: if (op_done) pw_r <= div_s;
      S_C_SDIVP: begin
        if (op_done) begin
          acc_r <= k_r[0] ? acc_r - div_s : acc_r + div_s;
          k_r   <= k_r + KW'(1);
        end
      end
      S_C_SFIN: if (op_done) e_r <= clamp_e(mul_fix);
      S_C_CFDIV: begin
        if (op_done) begin
          den_r <= z_r + div_fx;
          k_r   <= k_r - KW'(1);
        end
      end
      S_C_INV: if (op_done) inv_r <= div_fx;
      S_C_U: begin
        if (op_done) begin
          zz_r <= $signed(mul_fix) >>> EXP_SQUARINGS;
          ex_r <= Q_ONE;
          pw_r <= Q_ONE;
          k_r  <= KW'(1);
        end
      end
      S_C_EDIV: begin
        if (op_done) begin
          pw_r <= div_s;
          ex_r <= k_r[0] ? ex_r - div_s : ex_r + div_s;
          k_r  <= (k_r == KW'(EXP_TERMS)) ? '0 : k_r + KW'(1);
        end
      end
      S_C_ESQ: begin
        if (op_done) begin
          ex_r <= mul_fix;
          k_r  <= k_r + KW'(1);
        end
      end
      S_C_T2: if (op_done) e_r <= clamp_e(Q_ONE - mul_fix);
      default: ;
    endcase
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/rpcc_arith.sv
module rpcc_arith import rpcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  logic [63:0]  ma_r, mb_r, p_r;
  logic [2:0]   mcnt_r;
  logic [1:0]   psh_r;
  logic         mbusy_r, pvld_r;
  logic [127:0] acc_r;
  logic [127:0] num_r;
  logic [63:0]  rem_r, quo_r, den_r;
  logic         over_r, bad_r, dbusy_r, done_r;
  logic [7:0]   dcnt_r;

  logic [31:0]  a_half, b_half;
  logic [63:0]  prod_w;
  logic [127:0] acc_add;
  logic [63:0]  rem_sh, rem_new, quo_new;
  logic         ge;

  // Pick one 32x32 partial product per cycle
  assign a_half  = mcnt_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign b_half  = mcnt_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign prod_w  = a_half * b_half;
  assign acc_add = acc_r + ({64'b0, p_r} << {psh_r, 5'b0});

  // One restoring division step
  assign rem_sh  = {rem_r[62:0], num_r[127]};
  assign ge      = rem_sh >= den_r;
  assign rem_new = ge ? rem_sh - den_r : rem_sh;
  assign quo_new = {quo_r[62:0], ge};

  // Sequence both engines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      dbusy_r <= 1'b0;
      done_r  <= 1'b0;
      pvld_r  <= 1'b0;
      mcnt_r  <= '0;
      dcnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go_mul) begin
        mbusy_r <= 1'b1;
        mcnt_r  <= '0;
        pvld_r  <= 1'b0;
      end else if (mbusy_r) begin
        if (mcnt_r != 3'd4) begin
          mcnt_r <= mcnt_r + 3'd1;
          pvld_r <= 1'b1;
        end else begin
          mbusy_r <= 1'b0;
          pvld_r  <= 1'b0;
          done_r  <= 1'b1;
        end
      end
      if (req.go_div) begin
        dbusy_r <= 1'b1;
        dcnt_r  <= req.div_short ? 8'd64 : 8'd128;
      end else if (dbusy_r) begin
        dcnt_r <= dcnt_r - 8'd1;
        if (dcnt_r == 8'd1) begin
          dbusy_r <= 1'b0;
          done_r  <= 1'b1;
        end
      end
    end
  end

  // Operand and accumulator datapath
  always_ff @(posedge clk) begin
    if (req.go_mul) begin
      ma_r  <= req.opa;
      mb_r  <= req.opb;
      acc_r <= '0;
    end else if (mbusy_r) begin
      p_r   <= prod_w;
      psh_r <= {1'b0, mcnt_r[1]} + {1'b0, mcnt_r[0]};
      if (pvld_r) begin
        acc_r <= acc_add;
      end
    end
    if (req.go_div) begin
      num_r  <= req.div_short ? {req.opa, 64'b0} : {req.num_hi, req.opa};
      rem_r  <= '0;
      quo_r  <= '0;
      over_r <= 1'b0;
      den_r  <= req.opb;
      bad_r  <= (req.opb == '0) || req.opb[63];
    end else if (dbusy_r) begin
      num_r <= {num_r[126:0], 1'b0};
      rem_r <= rem_new;
      quo_r <= quo_new;
      if (quo_r[63]) begin
        over_r <= 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;
  assign rsp.quo  = bad_r ? '0 : (over_r ? '1 : quo_r);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench import rpcc_pkg::*;;

  localparam int  SERIES_N   = 32;
  localparam int  FRACTION_N = 32;
  localparam int  TAIL_WAIT  = 8000;
  localparam longint LIMIT   = 60_000_000;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam longint MAX_Q32  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint STEP_CAP = 64'h0000_0100_0000_0000;
  localparam int NUM_PHASES  = 16;
  localparam int PHASE_ITEMS = 125;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  ramp_and_probabilistic_cutoff_control_top #(
    .SERIES_TERMS(SERIES_N), .FRACTION_TERMS(FRACTION_N)
  ) u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  // Clock: 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register copies and held controller outputs
  logic [2:0] ctl_mode = MODE_NONE;
  longint gain = 65536, slope_hi = 0, slope_lo = 0;
  longint lim_hi = 0, lim_lo = 0, base_sp = 0;
  longint hold_sp = 0, hold_prob = 0;
  logic   hold_off = 1'b0;

  in_t    pending_items[$];
  out_t   expected_results[$];
  int     n_sent = 0, n_recv = 0, n_err = 0;
  longint cycles = 0;
  bit     item_taken = 1'b0;

  // ---------------- fixed-point helpers ----------------
  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] udiv_sat(logic [127:0] num, logic [63:0] den);
    logic [127:0] q;
    if (den == 0 || den[63]) return 64'd0;
    q = num / {64'd0, den};
    return (q[127:64] != 0) ? {64{1'b1}} : q[63:0];
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    logic [63:0]  r;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    r = p[95:32];
    if (p[127:96] != 0 || r[63]) r = MAX_Q32;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint qdiv(longint a, longint b);
    logic [63:0] r;
    if (b == 0) return 0;
    r = udiv_sat({32'd0, mag64(a), 32'd0}, mag64(b));
    if (r[63]) r = MAX_Q32;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint dec_q32(logic [63:0] digits);
    return longint'(udiv_sat({32'd0, digits, 32'd0}, 64'd1000000000000000000));
  endfunction

  // erf of a non-negative Q31.32 value
  function automatic longint erf_nonneg(longint z);
    longint acc, pw, zz, part, den, inv, u, ex, tail, res;
    if (z <= longint'((64'd22 << 32) / 10)) begin
      acc = z; pw = z; zz = qmul(z, z);
      for (int k = 1; k <= SERIES_N; k++) begin
        pw = qmul(pw, zz) / longint'(k);
        part = pw / longint'(2 * k + 1);
        acc = (k % 2 == 1) ? acc - part : acc + part;
      end
      res = qmul(dec_q32(64'd1128379167095512574), acc);
    end else if (z >= (longint'(6) << 32)) begin
      res = ONE_Q32;
    end else begin
      den = z; ex = ONE_Q32; pw = ONE_Q32;
      for (int k = FRACTION_N; k >= 1; k--) den = z + qdiv(longint'(k) << 31, den);
      inv = qdiv(ONE_Q32, den);
      u = qmul(z, z) >>> 6;
      for (int k = 1; k <= 16; k++) begin
        pw = qmul(pw, u) / longint'(k);
        ex = (k % 2 == 1) ? ex - pw : ex + pw;
      end
      for (int k = 0; k < 6; k++) ex = qmul(ex, ex);
      tail = qmul(qmul(dec_q32(64'd564189583547756287), ex), inv);
      res = ONE_Q32 - tail;
    end
    if (res < 0) res = 0;
    if (res > ONE_Q32) res = ONE_Q32;
    return res;
  endfunction

  // Work out the setpoint change for ramp mode and update the held outputs
  function automatic void ramp_setpoint(longint meas, longint expv, longint sd);
    longint dev, slope, limit, change, total;
    logic [127:0] p;
    logic [63:0]  quo;
    bit above, neg;
    dev = meas - expv;
    above = meas > expv;
    slope = above ? slope_hi : slope_lo;
    if (above) limit = slope > 0 ? lim_hi : lim_lo;
    else limit = slope > 0 ? lim_lo : lim_hi;
    if (gain == 0 || sd == 0) begin
      change = 0;
    end else begin
      neg = (dev < 0) != (gain < 0);
      p = {64'd0, 64'(mag64(dev) * mag64(limit))} * {64'd0, mag64(gain)};
      if (p == 0) begin
        change = 0;
      end else if (slope == 0) begin
        change = neg ? -STEP_CAP : STEP_CAP;
      end else begin
        quo = udiv_sat(p, 64'(mag64(slope) * 64'(sd)));
        if (quo > 64'(STEP_CAP)) quo = STEP_CAP;
        if (slope < 0) neg = !neg;
        change = neg ? -longint'(quo) : longint'(quo);
      end
    end
    if (change > lim_hi) change = lim_hi;
    if (change < lim_lo) change = lim_lo;
    total = base_sp + change;
    if (total > 64'sh7FFF_FFFF) total = 64'sh7FFF_FFFF;
    if (total < -64'sh8000_0000) total = -64'sh8000_0000;
    hold_sp = total;
    hold_off = 1'b0;
  endfunction

  // Cutoff probability from the normal CDF; decide whether to switch off
  function automatic void cutoff_decide(longint meas, longint mean, longint sd,
                                        longint rnd);
    longint dev, z, e, prob;
    logic [63:0] ad, ratio;
    if (sd == 0) begin
      hold_off = meas > mean;
      hold_prob = hold_off ? 65536 : 0;
      return;
    end
    dev = meas - mean;
    ad = mag64(dev);
    ratio = udiv_sat({32'd0, ad, 32'd0}, 64'(sd));
    if (ratio > (64'd16 << 32)) ratio = 64'd16 << 32;
    z = qmul(longint'(ratio), dec_q32(64'd707106781186547524));
    e = erf_nonneg(z);
    if (dev < 0) e = -e;
    prob = qmul(gain, e) / 2;
    hold_off = rnd < prob;
    hold_prob = prob < 0 ? 0 : prob;
  endfunction

  function automatic out_t controller_step(in_t it);
    out_t r;
    logic err;
    err = 1'b0;
    case (ctl_mode)
      MODE_RAMP: ramp_setpoint(longint'(it.measured), longint'(it.expected),
                               longint'(it.std_dev));
      MODE_CUTOFF: cutoff_decide(longint'(it.measured), longint'(it.mean_value),
                                 longint'(it.std_dev), longint'(it.random_fraction));
      MODE_DUTY, MODE_SPARE6, MODE_SPARE7: err = 1'b1;
      default: ;
    endcase
    r.new_setpoint    = hold_sp[31:0];
    r.turn_off        = hold_off;
    r.off_probability = hold_prob[30:0];
    r.mode_error      = err;
    return r;
  endfunction

  // ---------------- driver ----------------
  // Note acceptance and predict the result at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(controller_step(in_data));
      void'(pending_items.pop_front());
      n_sent++;
      item_taken = 1'b1;
    end
  end

  // Hold an unaccepted item, otherwise present the next one or idle
  always @(negedge clk) begin
    bit calm;
    calm = (n_sent >= 600 && n_sent < 900);
    if (!(in_valid && !item_taken)) begin
      item_taken = 1'b0;
      if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 22)) begin
        in_valid <= 1'b1;
        in_data  <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
    calm = (n_recv >= 1200 && n_recv < 1500);
    out_stall <= !calm && ($urandom_range(0, 99) < 22);
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_recv++;
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: %h", out_data);
        n_err++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.new_setpoint !== want.new_setpoint) begin
          $error("new_setpoint: expected %h, got %h", want.new_setpoint,
                 out_data.new_setpoint);
          n_err++;
        end
        if (out_data.turn_off !== want.turn_off) begin
          $error("turn_off: expected %b, got %b", want.turn_off, out_data.turn_off);
          n_err++;
        end
        if (out_data.off_probability !== want.off_probability) begin
          $error("off_probability: expected %h, got %h", want.off_probability,
                 out_data.off_probability);
          n_err++;
        end
        if (out_data.mode_error !== want.mode_error) begin
          $error("mode_error: expected %b, got %b", want.mode_error,
                 out_data.mode_error);
          n_err++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    case (idx)
      REG_MODE:       ctl_mode = val[2:0];
      REG_SENS:       gain     = longint'(signed'(val));
      REG_RAMP_HIGH:  slope_hi = longint'(signed'(val));
      REG_RAMP_LOW:   slope_lo = longint'(signed'(val));
      REG_RANGE_HIGH: lim_hi   = longint'(signed'(val));
      REG_RANGE_LOW:  lim_lo   = longint'(signed'(val));
      REG_BASE:       base_sp  = longint'(signed'(val));
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain all outstanding work before touching the registers
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  task automatic set_all(logic [2:0] m, logic [31:0] s, logic [31:0] rh,
                         logic [31:0] rl, logic [31:0] gh, logic [31:0] gl,
                         logic [31:0] b);
    wait_drained();
    write_reg(REG_MODE, {29'd0, m});
    write_reg(REG_SENS, s);
    write_reg(REG_RAMP_HIGH, rh);
    write_reg(REG_RAMP_LOW, rl);
    write_reg(REG_RANGE_HIGH, gh);
    write_reg(REG_RANGE_LOW, gl);
    write_reg(REG_BASE, b);
  endtask

  task automatic push(logic [31:0] m, logic [31:0] e, logic [31:0] mn,
                      logic [30:0] sd, logic [15:0] r);
    in_t it;
    it.measured = m; it.expected = e; it.mean_value = mn;
    it.std_dev = sd; it.random_fraction = r;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'h0001_0000;
      4: return 32'hFFFF_0000;
      5: return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic ramp_item();
    logic [31:0] m, e;
    logic [30:0] sd;
    m = $urandom;
    e = $urandom_range(0, 1) ? $urandom : m + $urandom_range(0, 1 << 18) - (1 << 17);
    case ($urandom_range(0, 7))
      0: sd = '0;
      1: sd = '1;
      2, 3: sd = $urandom_range(1, 1 << 17);
      default: sd = $urandom;
    endcase
    push(m, e, $urandom, sd, $urandom);
  endtask

  // Mostly deviations a few sigma wide, some noise
  task automatic cutoff_item();
    logic [31:0] mn, dev;
    logic [30:0] sd;
    longint f;
    case ($urandom_range(0, 9))
      0: sd = '0;
      1: sd = $urandom;
      default: sd = $urandom_range(1, 1 << 20);
    endcase
    mn = $urandom;
    f = longint'($urandom_range(0, 900));
    dev = 32'((longint'(sd) * f) / 100);
    if ($urandom_range(0, 1)) dev = -dev;
    if ($urandom_range(0, 9) == 0) push($urandom, $urandom, mn, sd, $urandom);
    else push(mn + dev, $urandom, mn, sd, $urandom);
  endtask

  initial begin
    logic [2:0] hold_modes[6];
    logic [2:0] m;
    int r;
    hold_modes = '{MODE_NONE, MODE_CND, MODE_DUTY, MODE_THIRD, MODE_SPARE6,
                   MODE_SPARE7};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: hold modes right after reset, then every hold code
    push(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, '1, 16'hFFFF);
    foreach (hold_modes[i]) begin
      wait_drained();
      write_reg(REG_MODE, {29'd0, hold_modes[i]});
      push($urandom, $urandom, $urandom, $urandom, $urandom);
    end
    wait_drained();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);

    // Directed ramp: both directions, zero deviation, zero sigma, extremes
    set_all(MODE_RAMP, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
            32'h000A_0000, 32'hFFF6_0000, 32'h0064_0000);
    push(32'h0003_0000, 32'h0001_0000, 0, 31'h0001_0000, 0);
    push(32'h0001_0000, 32'h0003_0000, 0, 31'h0001_0000, 0);
    push(32'h0005_0000, 32'h0005_0000, 0, 31'h0001_0000, 0);
    push(32'h0009_0000, 32'h0001_0000, 0, 31'h0, 0);
    push(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1, 16'hFFFF);
    push(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 16'h0);
    // Zero slope saturates by sign; zero gain gives no change
    set_all(MODE_RAMP, 32'hFFFF_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF);
    push(32'h0002_0000, 32'h0001_0000, 0, 31'h0001_0000, 0);
    push(32'h0001_0000, 32'h0002_0000, 0, 31'h0001_0000, 0);
    wait_drained();
    write_reg(REG_SENS, 32'h0);
    push(32'h0004_0000, 32'h0001_0000, 0, 31'h0001_0000, 0);

    // Directed cutoff: zero sigma both ways, series, fraction, saturation
    set_all(MODE_CUTOFF, 32'h0001_0000, 0, 0, 0, 0, 0);
    push(32'h0002_0000, 0, 32'h0001_0000, 31'h0, 16'h0);
    push(32'h0001_0000, 0, 32'h0001_0000, 31'h0, 16'h0);
    push(32'h0000_8000, 0, 32'h0, 31'h0001_0000, 16'h1000);
    push(32'h0002_0000, 0, 32'h0, 31'h0001_0000, 16'h4000);
    push(32'h0005_0000, 0, 32'h0, 31'h0001_0000, 16'h7000);
    push(32'h000C_0000, 0, 32'h0, 31'h0001_0000, 16'h7FFF);
    push(32'hFFFE_0000, 0, 32'h0, 31'h0001_0000, 16'h0);
    push(32'h7FFF_FFFF, 0, 32'h8000_0000, 31'd1, 16'h0);
    wait_drained();
    write_reg(REG_SENS, 32'h7FFF_FFFF);
    push(32'h0004_0000, 0, 32'h0, 31'h0002_0000, 16'hFFFF);

    // Random phases with random settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      r = $urandom_range(0, 99);
      if (r < 45) m = MODE_RAMP;
      else if (r < 65) m = MODE_CUTOFF;
      else m = hold_modes[$urandom_range(0, 5)];
      set_all(m, pick32(), pick32(), pick32(), pick32(), pick32(), pick32());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (m == MODE_CUTOFF) cutoff_item();
        else ramp_item();
      end
    end

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (n_err == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
